FILE: src/rjrb_pkg.sv
// Shared constants and types for the jitter reorder buffer.
`default_nettype none
package rjrb_pkg;

   localparam int MAX_SLOTS_DEFAULT   = 64;
   localparam logic [6:0]  SLOT_COUNT_RESET  = 7'd20;
   localparam logic [15:0] WATER_LEVEL_RESET = 16'd10;

   localparam int SEQ_W   = 16;
   localparam int TAG_W   = 16;
   localparam int CNT_W   = 32;
   localparam int REQ_W   = 40;
   localparam int RSP_W   = 192;
   localparam int CSR_AW  = 3;

   localparam logic REG_SLOT_COUNT  = 1'b0;
   localparam logic REG_WATER_LEVEL = 1'b1;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_PEEK   = 2'd1,
      OP_POP    = 2'd2,
      OP_POP_PK = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_STORED    = 3'd0,
      ST_OUT_WIN   = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_DELIVERED = 3'd3,
      ST_NOTHING   = 3'd4,
      ST_STALE     = 3'd5,
      ST_NO_PEEK   = 3'd6
   } status_type;

   typedef struct packed {
      logic [CNT_W-1:0] stale_total;
      logic [CNT_W-1:0] deliver_total;
      logic [CNT_W-1:0] store_total;
      logic [CNT_W-1:0] drop_total;
      logic [SEQ_W-1:0] next_seq;
      logic [6:0]       held_count;
      logic [TAG_W-1:0] out_tag;
      logic [SEQ_W-1:0] out_seq;
      logic             flushed;
      status_type       status;
   } rsp_type;

endpackage
`default_nettype wire

FILE: src/rjrb_ram.sv
// Generic single-address RAM with registered read.
`default_nettype none
module rjrb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

FILE: src/rjrb_mod_unit.sv
// Bit-serial remainder unit: dividend modulo slot count, one bit per cycle.
`default_nettype none
module rjrb_mod_unit #(
   parameter int MAX_SLOTS = rjrb_pkg::MAX_SLOTS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [rjrb_pkg::SEQ_W-1:0]     dividend,
   input  wire logic [$clog2(MAX_SLOTS+1)-1:0] divisor,
   output logic                                done,
   output logic      [$clog2(MAX_SLOTS)-1:0]   rem
);
   localparam int NW = $clog2(MAX_SLOTS + 1);
   localparam int IW = $clog2(MAX_SLOTS);
   localparam int SW = rjrb_pkg::SEQ_W;
   localparam int KW = $clog2(SW + 1);

   logic [SW-1:0] shift_ff, shift_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [KW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [NW:0]   trial;

   always_comb begin
      trial    = {rem_ff, shift_ff[SW-1]};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = KW'(SW);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[SW-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = NW'(trial - {1'b0, divisor});
         end else begin
            rem_in = NW'(trial);
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == KW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff[IW-1:0];
endmodule
`default_nettype wire

FILE: src/rtp_jitter_reorder_buffer_top.sv
// Top level of the jitter reorder buffer: register port, sequencer and slot store.
// Each command passes through these states: idle to accept it, S_DIV while the bit-serial
// remainder unit maps a sequence number onto its slot (its bit steps plus its done
// register; slot count is a register value), S_EXEC to decide and update state, S_CMP
// to check the slot read-back when a peek or pop finds a held slot, S_POP for the pop
// step on a pop peeked or on a pop that delivers, and S_FIN to load the result register,
// which waits while the receiver holds off a waiting result. The input is not ready while a
// command is in work; a finished result waits in the output register while the next
// command is taken. Slot valid bits clear at reset and on flush at once.
`default_nettype none
module rtp_jitter_reorder_buffer_top #(
   parameter int MAX_SLOTS = rjrb_pkg::MAX_SLOTS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // op[1:0], seq_num[17:2], payload_tag[33:18], zero pad
   input  wire logic [rjrb_pkg::REQ_W-1:0]   req_tdata,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // status[2:0], flushed[3], out_seq[19:4], out_tag[35:20], held_count[42:36],
   // next_seq[58:43], drop_total[90:59], store_total[122:91],
   // deliver_total[154:123], stale_total[186:155], zero pad
   output logic      [rjrb_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [rjrb_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [31:0]                  csr_pwdata,
   output logic      [31:0]                  csr_prdata,
   output logic                              csr_pready
);
   localparam int NW = $clog2(MAX_SLOTS + 1);
   localparam int IW = $clog2(MAX_SLOTS);
   localparam int SW = rjrb_pkg::SEQ_W;
   localparam int TW = rjrb_pkg::TAG_W;
   localparam int CW = rjrb_pkg::CNT_W;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_DIV  = 6'b000010,
      S_EXEC = 6'b000100,
      S_CMP  = 6'b001000,
      S_POP  = 6'b010000,
      S_FIN  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [6:0]  slot_count_ff, slot_count_in;
   logic [15:0] water_level_ff, water_level_in;
   logic [NW-1:0] n_slots;

   rjrb_pkg::op_type     op_ff, op_in;
   logic [SW-1:0]        seq_ff, seq_in;
   logic [TW-1:0]        tag_ff, tag_in;
   logic [IW-1:0]        idx_ff, idx_in;
   rjrb_pkg::status_type status_ff, status_in;
   logic                 flushed_ff, flushed_in;
   logic [SW-1:0]        os_ff, os_in;
   logic [TW-1:0]        ot_ff, ot_in;

   logic [SW-1:0]        next_out_ff, next_out_in;
   logic                 pend_ff, pend_in;
   logic [SW-1:0]        pseq_ff, pseq_in;
   logic [TW-1:0]        ptag_ff, ptag_in;
   logic                 orph_ff, orph_in;
   logic [NW-1:0]        held_ff, held_in;
   logic [MAX_SLOTS-1:0] valid_ff, valid_in;
   logic [CW-1:0]        drops_ff, drops_in, stores_ff, stores_in;
   logic [CW-1:0]        delivers_ff, delivers_in, stales_ff, stales_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rjrb_pkg::rsp_type    rsp_ff, rsp_in;

   logic                 mod_start, mod_done;
   logic [IW-1:0]        mod_rem;
   logic                 ram_we;
   logic [SW+TW-1:0]     ram_rdata;
   logic                 req_fire, csr_write;

   logic [NW:0]          used;
   logic                 full, orph_a;
   logic [NW-1:0]        held_a;
   logic [MAX_SLOTS-1:0] valid_a;
   logic [SW-1:0]        next_a, span;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      slot_count_in  = slot_count_ff;
      water_level_in = water_level_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            rjrb_pkg::REG_SLOT_COUNT:  slot_count_in  = csr_pwdata[6:0];
            rjrb_pkg::REG_WATER_LEVEL: water_level_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
      unique case (csr_paddr[2])
         rjrb_pkg::REG_SLOT_COUNT:  csr_prdata = {25'd0, slot_count_ff};
         rjrb_pkg::REG_WATER_LEVEL: csr_prdata = {16'd0, water_level_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (slot_count_ff == 7'd0) begin
         n_slots = NW'(1);
      end else if (32'(slot_count_ff) > MAX_SLOTS) begin
         n_slots = NW'(MAX_SLOTS);
      end else begin
         n_slots = NW'(slot_count_ff);
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign mod_start  = req_fire;

   rjrb_mod_unit #(.MAX_SLOTS(MAX_SLOTS)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend ((rjrb_pkg::op_type'(req_tdata[1:0]) == rjrb_pkg::OP_PUSH) ?
                 req_tdata[17:2] : next_out_ff),
      .divisor  (n_slots),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   rjrb_ram #(.WIDTH(SW + TW), .DEPTH(MAX_SLOTS)) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (idx_ff),
      .wdata ({tag_ff, seq_ff}),
      .rdata (ram_rdata)
   );

   // push bookkeeping after an optional flush
   always_comb begin
      used    = (NW + 1)'(held_ff) + (NW + 1)'(orph_ff);
      full    = used >= (NW + 1)'(n_slots);
      held_a  = full ? '0 : held_ff;
      orph_a  = full ? (orph_ff || pend_ff) : orph_ff;
      valid_a = full ? '0 : valid_ff;
      next_a  = ((held_a == '0) && !orph_a) ? (seq_ff - water_level_ff) : next_out_ff;
      span    = seq_ff - next_a;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      seq_in       = seq_ff;
      tag_in       = tag_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      flushed_in   = flushed_ff;
      os_in        = os_ff;
      ot_in        = ot_ff;
      next_out_in  = next_out_ff;
      pend_in      = pend_ff;
      pseq_in      = pseq_ff;
      ptag_in      = ptag_ff;
      orph_in      = orph_ff;
      held_in      = held_ff;
      valid_in     = valid_ff;
      drops_in     = drops_ff;
      stores_in    = stores_ff;
      delivers_in  = delivers_ff;
      stales_in    = stales_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in      = rjrb_pkg::op_type'(req_tdata[1:0]);
               seq_in     = req_tdata[17:2];
               tag_in     = req_tdata[33:18];
               flushed_in = 1'b0;
               os_in      = '0;
               ot_in      = '0;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            if (mod_done) begin
               idx_in   = mod_rem;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FIN;
            if (op_ff == rjrb_pkg::OP_PUSH) begin
               valid_in   = valid_a;
               held_in    = held_a;
               orph_in    = orph_a;
               flushed_in = full;
               if (full && orph_a && (n_slots == NW'(1))) begin
                  drops_in  = drops_ff + 1'b1;
                  status_in = rjrb_pkg::ST_OUT_WIN;
               end else begin
                  next_out_in = next_a;
                  if (32'(span) > 32'(n_slots)) begin
                     drops_in  = drops_ff + 1'b1;
                     status_in = rjrb_pkg::ST_OUT_WIN;
                  end else if (valid_a[idx_ff]) begin
                     drops_in  = drops_ff + 1'b1;
                     status_in = rjrb_pkg::ST_DUPLICATE;
                  end else begin
                     valid_in[idx_ff] = 1'b1;
                     held_in   = held_a + 1'b1;
                     stores_in = stores_ff + 1'b1;
                     ram_we    = 1'b1;
                     status_in = rjrb_pkg::ST_STORED;
                  end
               end
            end else if (op_ff == rjrb_pkg::OP_POP_PK) begin
               state_in = S_POP;
            end else if (pend_ff) begin
               status_in = rjrb_pkg::ST_DELIVERED;
               os_in     = pseq_ff;
               ot_in     = ptag_ff;
               state_in  = (op_ff == rjrb_pkg::OP_POP) ? S_POP : S_FIN;
            end else if (!valid_ff[idx_ff]) begin
               next_out_in = next_out_ff + 1'b1;
               status_in   = rjrb_pkg::ST_NOTHING;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_FIN;
            if (ram_rdata[SW-1:0] != next_out_ff) begin
               valid_in[idx_ff] = 1'b0;
               if (held_ff != '0) begin
                  held_in = held_ff - 1'b1;
               end
               stales_in = stales_ff + 1'b1;
               status_in = rjrb_pkg::ST_STALE;
            end else begin
               pend_in   = 1'b1;
               orph_in   = 1'b0;
               pseq_in   = ram_rdata[SW-1:0];
               ptag_in   = ram_rdata[SW+TW-1:SW];
               os_in     = ram_rdata[SW-1:0];
               ot_in     = ram_rdata[SW+TW-1:SW];
               status_in = rjrb_pkg::ST_DELIVERED;
               if (op_ff == rjrb_pkg::OP_POP) begin
                  state_in = S_POP;
               end
            end
         end
         S_POP: begin
            state_in    = S_FIN;
            next_out_in = next_out_ff + 1'b1;
            if (!pend_ff) begin
               status_in = rjrb_pkg::ST_NO_PEEK;
            end else begin
               os_in   = pseq_ff;
               ot_in   = ptag_ff;
               pend_in = 1'b0;
               if (orph_ff) begin
                  orph_in = 1'b0;
               end else if (valid_ff[idx_ff]) begin
                  valid_in[idx_ff] = 1'b0;
                  if (held_ff != '0) begin
                     held_in = held_ff - 1'b1;
                  end
               end
               delivers_in = delivers_ff + 1'b1;
               status_in   = rjrb_pkg::ST_DELIVERED;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in.status        = status_ff;
               rsp_in.flushed       = flushed_ff;
               rsp_in.out_seq       = os_ff;
               rsp_in.out_tag       = ot_ff;
               rsp_in.held_count    = 7'(held_ff);
               rsp_in.next_seq      = next_out_ff;
               rsp_in.drop_total    = drops_ff;
               rsp_in.store_total   = stores_ff;
               rsp_in.deliver_total = delivers_ff;
               rsp_in.stale_total   = stales_ff;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         slot_count_ff  <= rjrb_pkg::SLOT_COUNT_RESET;
         water_level_ff <= rjrb_pkg::WATER_LEVEL_RESET;
         next_out_ff    <= '0;
         pend_ff        <= 1'b0;
         pseq_ff        <= '0;
         ptag_ff        <= '0;
         orph_ff        <= 1'b0;
         held_ff        <= '0;
         valid_ff       <= '0;
         drops_ff       <= '0;
         stores_ff      <= '0;
         delivers_ff    <= '0;
         stales_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         slot_count_ff  <= slot_count_in;
         water_level_ff <= water_level_in;
         next_out_ff    <= next_out_in;
         pend_ff        <= pend_in;
         pseq_ff        <= pseq_in;
         ptag_ff        <= ptag_in;
         orph_ff        <= orph_in;
         held_ff        <= held_in;
         valid_ff       <= valid_in;
         drops_ff       <= drops_in;
         stores_ff      <= stores_in;
         delivers_ff    <= delivers_in;
         stales_ff      <= stales_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff      <= op_in;
      seq_ff     <= seq_in;
      tag_ff     <= tag_in;
      idx_ff     <= idx_in;
      status_ff  <= status_in;
      flushed_ff <= flushed_in;
      os_ff      <= os_in;
      ot_ff      <= ot_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff};
endmodule
`default_nettype wire
